>>> src/fsg_pkg.sv
`timescale 1ns / 1ps
// Package for the falling sand grid stepper: cell and command codes,
// register indexes, controller state type and the controller-to-datapath struct.
// No dependencies.
package fsg_pkg;

    typedef logic [1:0] cell_t;

    localparam cell_t CELL_AIR  = 2'd0;
    localparam cell_t CELL_SNOW = 2'd1;
    localparam cell_t CELL_WALL = 2'd2;
    localparam cell_t CELL_SAND = 2'd3;

    typedef logic [1:0] cmd_t;

    localparam cmd_t CMD_WRITE = 2'd0;
    localparam cmd_t CMD_READ  = 2'd1;
    localparam cmd_t CMD_STEP  = 2'd2;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam int CFG_DATA_W = 7;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESP,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic clr_wr;      // clearing pass writes air at the counter address
        logic acc;         // a command item is accepted this cycle
        logic scan_issue;  // scan reads the cell one up and left of the counter position
    } dp_ctl_t;

endpackage

>>> src/fsg_ctrl.sv
`timescale 1ns / 1ps
// Controller of the falling sand grid stepper: command state machine and the
// row and column scan counters. Depends on fsg_pkg.
module fsg_ctrl #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int CW = $clog2(MAX_WIDTH + 1),
    parameter int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [1:0]       cmd,
    output logic             busy,
    output logic             done,
    output fsg_pkg::dp_ctl_t ctl,
    output logic [CW-1:0]    cnt_c,
    output logic [RW-1:0]    cnt_r
);

    fsg_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   cnt_c_reg, cnt_c_next;
    logic [RW-1:0]   cnt_r_reg, cnt_r_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fsg_pkg::ST_CLEAR;
            cnt_c_reg <= CW'(MAX_WIDTH - 1);
            cnt_r_reg <= RW'(MAX_HEIGHT - 1);
        end
        else
        begin
            state_reg <= state_next;
            cnt_c_reg <= cnt_c_next;
            cnt_r_reg <= cnt_r_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_c_next = cnt_c_reg;
        cnt_r_next = cnt_r_reg;
        busy       = 1'b1;
        done       = 1'b0;
        ctl        = '0;
        case (state_reg)
            fsg_pkg::ST_CLEAR:
            begin
                ctl.clr_wr = 1'b1;
                if (cnt_c_reg == '0)
                begin
                    if (cnt_r_reg == '0)
                    begin
                        state_next = fsg_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cnt_r_next = cnt_r_reg - 1'b1;
                        cnt_c_next = CW'(MAX_WIDTH - 1);
                    end
                end
                else
                begin
                    cnt_c_next = cnt_c_reg - 1'b1;
                end
            end
            fsg_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.acc = 1'b1;
                    if (cmd == fsg_pkg::CMD_STEP)
                    begin
                        cnt_r_next = RW'(MAX_HEIGHT);
                        cnt_c_next = CW'(MAX_WIDTH);
                        state_next = fsg_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = fsg_pkg::ST_RESP;
                    end
                end
            end
            fsg_pkg::ST_RESP:
            begin
                done       = 1'b1;
                state_next = fsg_pkg::ST_IDLE;
            end
            fsg_pkg::ST_SCAN:
            begin
                ctl.scan_issue = 1'b1;
                if (cnt_c_reg == '0)
                begin
                    if (cnt_r_reg == '0)
                    begin
                        state_next = fsg_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        cnt_r_next = cnt_r_reg - 1'b1;
                        cnt_c_next = CW'(MAX_WIDTH);
                    end
                end
                else
                begin
                    cnt_c_next = cnt_c_reg - 1'b1;
                end
            end
            fsg_pkg::ST_DRAIN:
            begin
                done       = 1'b1;
                state_next = fsg_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = fsg_pkg::ST_IDLE;
            end
        endcase
    end

    assign cnt_c = cnt_c_reg;
    assign cnt_r = cnt_r_reg;

endmodule

>>> src/fsg_datapath.sv
`timescale 1ns / 1ps
// Datapath of the falling sand grid stepper: size registers, grid memory,
// two-row line buffer, move logic and result registers. Depends on fsg_pkg.
module fsg_datapath #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int CW = $clog2(MAX_WIDTH + 1),
    parameter int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fsg_pkg::dp_ctl_t               ctl,
    input  logic [CW-1:0]                  cnt_c,
    input  logic [RW-1:0]                  cnt_r,
    input  logic [1:0]                     cmd,
    input  logic [5:0]                     col,
    input  logic [5:0]                     row,
    input  logic [1:0]                     cell_in,
    input  logic                           cfg_we,
    input  logic                           cfg_index,
    input  logic [fsg_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic [1:0]                     cell_out,
    output logic                           out_of_range
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int LEN   = MAX_WIDTH + 2;
    localparam int CMPW  = (CW > RW) ? ((CW > 7) ? CW : 7) : ((RW > 7) ? RW : 7);
    localparam logic [AW-1:0] W_AW = AW'(MAX_WIDTH);

    logic [fsg_pkg::CFG_DATA_W-1:0] grid_width_reg, grid_height_reg;
    logic [CW-1:0] eff_w;
    logic [RW-1:0] eff_h;

    logic [1:0]    mem [DEPTH];
    logic [1:0]    rdata_reg;
    logic [AW-1:0] raddr, waddr, port_addr;
    logic [1:0]    wdata;
    logic          we;

    logic          pr_vld_reg;
    logic [CW-1:0] pr_c_reg;
    logic [RW-1:0] pr_r_reg;

    fsg_pkg::cell_t line_reg [LEN];
    fsg_pkg::cell_t line_new [LEN];
    fsg_pkg::cell_t part;
    fsg_pkg::cell_t mat;
    logic           in_grid, below, right_ok, left_ok, scan_wr;
    logic           in_range, line_clr;
    logic [RW-1:0]  iss_r;
    logic [CW-1:0]  iss_c;

    logic resp_oor_reg, resp_rd_reg;

    // Size registers, written through the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= 7'd64;
            grid_height_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fsg_pkg::REG_WIDTH:  grid_width_reg  <= cfg_data;
                fsg_pkg::REG_HEIGHT: grid_height_reg <= cfg_data;
                default:             grid_width_reg  <= grid_width_reg;
            endcase
        end
    end

    // Sizes in use, clamped to 1..maximum.
    always_comb
    begin
        if (grid_width_reg == '0)
            eff_w = CW'(1);
        else if (CMPW'(grid_width_reg) > CMPW'(MAX_WIDTH))
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(grid_width_reg);
        if (grid_height_reg == '0)
            eff_h = RW'(1);
        else if (CMPW'(grid_height_reg) > CMPW'(MAX_HEIGHT))
            eff_h = RW'(MAX_HEIGHT);
        else
            eff_h = RW'(grid_height_reg);
    end

    assign in_range  = (CMPW'(col) < CMPW'(eff_w)) && (CMPW'(row) < CMPW'(eff_h));
    assign port_addr = AW'(row) * W_AW + AW'(col);
    assign line_clr  = ctl.acc && (cmd == fsg_pkg::CMD_STEP);

    // The scan counters sit one past the cell they read, so the cell is one up and left.
    assign iss_r = cnt_r - 1'b1;
    assign iss_c = cnt_c - 1'b1;
    assign raddr = ctl.scan_issue ? (AW'(iss_r) * W_AW + AW'(iss_c)) : port_addr;

    // Scan stage: the registered position is (x + 1, y + 1) of the cell being moved.
    assign in_grid  = pr_r_reg != '0 && pr_c_reg != '0 && pr_c_reg <= eff_w && pr_r_reg <= eff_h;
    assign below    = pr_r_reg < eff_h;
    assign right_ok = pr_c_reg < eff_w;
    assign left_ok  = pr_c_reg >= CW'(2);
    assign mat      = in_grid ? rdata_reg : fsg_pkg::CELL_AIR;
    assign scan_wr  = pr_vld_reg && (pr_c_reg <= CW'(MAX_WIDTH - 1))
                      && (pr_r_reg < RW'(MAX_HEIGHT));

    // Line entry 0 is the next-grid cell below-right, 1 below, 2 below-left.
    always_comb
    begin
        for (int j = 0; j < LEN; j++)
        begin
            line_new[j] = line_reg[j];
        end
        part = fsg_pkg::CELL_AIR;
        case (mat)
            fsg_pkg::CELL_SNOW:
            begin
                if (below && line_reg[1] == fsg_pkg::CELL_AIR)
                    line_new[1] = fsg_pkg::CELL_SNOW;
                else
                    part = fsg_pkg::CELL_SNOW;
            end
            fsg_pkg::CELL_SAND:
            begin
                if (below && line_reg[1] == fsg_pkg::CELL_AIR)
                    line_new[1] = fsg_pkg::CELL_SAND;
                else if (below && right_ok && line_reg[0] == fsg_pkg::CELL_AIR)
                    line_new[0] = fsg_pkg::CELL_SAND;
                else if (below && left_ok && line_reg[2] == fsg_pkg::CELL_AIR)
                    line_new[2] = fsg_pkg::CELL_SAND;
                else
                    part = fsg_pkg::CELL_SAND;
            end
            fsg_pkg::CELL_WALL:
            begin
                part = fsg_pkg::CELL_WALL;
            end
            default:
            begin
                part = fsg_pkg::CELL_AIR;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (line_clr)
        begin
            for (int j = 0; j < LEN; j++)
            begin
                line_reg[j] <= fsg_pkg::CELL_AIR;
            end
        end
        else if (pr_vld_reg)
        begin
            for (int j = 0; j < LEN - 1; j++)
            begin
                line_reg[j] <= line_new[j + 1];
            end
            line_reg[LEN - 1] <= part;
        end
    end

    // Memory write port: clearing pass, final next-grid cells, or a write command.
    always_comb
    begin
        we    = 1'b0;
        waddr = port_addr;
        wdata = cell_in;
        if (ctl.clr_wr)
        begin
            we    = 1'b1;
            waddr = AW'(cnt_r) * W_AW + AW'(cnt_c);
            wdata = fsg_pkg::CELL_AIR;
        end
        else if (scan_wr)
        begin
            we    = 1'b1;
            waddr = AW'(pr_r_reg) * W_AW + AW'(pr_c_reg);
            wdata = line_new[0];
        end
        else if (ctl.acc && cmd == fsg_pkg::CMD_WRITE && in_range)
        begin
            we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        pr_c_reg <= cnt_c;
        pr_r_reg <= cnt_r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_vld_reg   <= 1'b0;
            resp_oor_reg <= 1'b0;
            resp_rd_reg  <= 1'b0;
        end
        else
        begin
            pr_vld_reg <= ctl.scan_issue;
            if (ctl.acc)
            begin
                resp_oor_reg <= (cmd inside {fsg_pkg::CMD_WRITE, fsg_pkg::CMD_READ})
                                && !in_range;
                resp_rd_reg  <= (cmd == fsg_pkg::CMD_READ) && in_range;
            end
        end
    end

    assign cell_out     = resp_rd_reg ? rdata_reg : fsg_pkg::CELL_AIR;
    assign out_of_range = resp_oor_reg;

endmodule

>>> src/falling_sand_grid_step_top.sv
`timescale 1ns / 1ps
// Top level of the falling sand grid stepper: controller plus datapath.
// Depends on fsg_pkg, fsg_ctrl and fsg_datapath.
//
// Usage. A command item (cmd, col, row, cell_in) is taken at a clock edge where
// start is high and busy is low. Command 0 writes one cell, 1 reads one cell,
// 2 runs one generation of the falling sand rules; code 3 does nothing.
// Each item returns exactly one result: done is high for one cycle with
// cell_out and out_of_range valid. The receiver cannot stall, so it must
// take the result in that cycle.
// A write, read or unused command answers in the cycle after it is taken,
// and the block is ready again in the cycle after that.
// A generation scans every position of the full grid memory, one cell per
// cycle through the single memory read port, with one extra column and row
// for the two-row line buffer, and then raises done.
// The size registers are written through cfg_valid / cfg_ready / cfg_index /
// cfg_data (index 0 width, index 1 height); cfg_ready is always high and
// writes are meant to happen only while the block is idle.
// After reset the block clears the grid memory to air, one cell per cycle,
// with busy held high; size writes are still taken during that pass.
module falling_sand_grid_step_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] cmd,
    input  logic [5:0] col,
    input  logic [5:0] row,
    input  logic [1:0] cell_in,
    output logic       done,
    output logic [1:0] cell_out,
    output logic       out_of_range,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [6:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    fsg_pkg::dp_ctl_t ctl;
    logic [CW-1:0]    cnt_c;
    logic [RW-1:0]    cnt_r;
    logic             cfg_we;

    // Size registers have no side effects, so the port never pushes back.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // The controller sequences the clearing pass, single-cell commands and
    // the generation scan; it hands the datapath only strobes and counters.
    fsg_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl),
        .cnt_c (cnt_c),
        .cnt_r (cnt_r)
    );

    // The datapath holds the grid memory and applies the move rules while
    // writing each finished next-grid cell straight back into the grid.
    fsg_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .CW         (CW),
        .RW         (RW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .cnt_c        (cnt_c),
        .cnt_r        (cnt_r),
        .cmd          (cmd),
        .col          (col),
        .row          (row),
        .cell_in      (cell_in),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cell_out     (cell_out),
        .out_of_range (out_of_range)
    );

endmodule
